// ===== rtl/base64_field_anchor_extractor_macros.svh =====
// Assertion macros shared by the extractor RTL.
`ifndef BASE64_FIELD_ANCHOR_EXTRACTOR_MACROS_SVH
`define BASE64_FIELD_ANCHOR_EXTRACTOR_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define BFAE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define BFAE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BFAE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BFAE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/bfae_pkg.sv =====
`default_nettype none

package bfae_pkg;

  // Fixed field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 10;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned MPOS_W = 5;
  localparam int unsigned APOS_W = 4;
  localparam int unsigned ACC_W  = 12;

  // Parameter defaults.
  localparam int unsigned MARKER_LEN_DEF  = 20;
  localparam int unsigned ANCHOR_LEN_DEF  = 9;
  localparam int unsigned CAPTURE_MAX_DEF = 1023;

  // Reset value of the capture length register.
  localparam logic [CFG_W-1:0] CAP_LEN_RST = 10'd800;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_NO_FIELD  = 2'd1,
    ST_NO_ANCHOR = 2'd2,
    ST_FIELD_END = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              start_req;
    logic              stream_end;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    status_t           status;
    logic              last;
  } out_item_t;

  // Key marker text; positions beyond the text read as zero.
  function automatic logic [BYTE_W-1:0] key_byte(input logic [MPOS_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      5'd0:    b = "\"";
      5'd1:    b = "h";
      5'd2:    b = "t";
      5'd3:    b = "t";
      5'd4:    b = "p";
      5'd5:    b = "R";
      5'd6:    b = "e";
      5'd7:    b = "s";
      5'd8:    b = "p";
      5'd9:    b = "o";
      5'd10:   b = "n";
      5'd11:   b = "s";
      5'd12:   b = "e";
      5'd13:   b = "B";
      5'd14:   b = "o";
      5'd15:   b = "d";
      5'd16:   b = "y";
      5'd17:   b = "\"";
      5'd18:   b = ":";
      5'd19:   b = "\"";
      default: b = '0;
    endcase
    return b;
  endfunction

  // Anchor text; positions beyond the text read as zero.
  function automatic logic [BYTE_W-1:0] tag_byte(input logic [APOS_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      4'd0:    b = "c";
      4'd1:    b = "l";
      4'd2:    b = "a";
      4'd3:    b = "s";
      4'd4:    b = "s";
      4'd5:    b = "=";
      4'd6:    b = "h";
      4'd7:    b = "2";
      4'd8:    b = ">";
      default: b = '0;
    endcase
    return b;
  endfunction

  // Base64 alphabet lookup: bit 6 is set for a member, bits 5:0 hold its value.
  function automatic logic [6:0] sextet_of(input logic [BYTE_W-1:0] ch);
    logic [6:0] r;
    r = '0;
    if (ch >= "A" && ch <= "Z") begin
      r = {1'b1, 6'(ch - "A")};
    end else if (ch >= "a" && ch <= "z") begin
      r = {1'b1, 6'(ch - "a" + 8'd26)};
    end else if (ch >= "0" && ch <= "9") begin
      r = {1'b1, 6'(ch - "0" + 8'd52)};
    end else if (ch == "+") begin
      r = {1'b1, 6'd62};
    end else if (ch == "/") begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/base64_field_anchor_extractor.sv =====
// Streaming field and anchor extractor.
// Input channel (in_valid/in_ready/in_data) carries one raw response byte per
// transaction, with start_req opening a new response and stream_end closing it.
// The block looks for the JSON key marker, base64-decodes what follows, looks
// for the anchor in the decoded bytes and then emits the anchor and the decoded
// bytes after it on the output channel (out_valid/out_ready/out_data).
// Status-only results report a missing field, a missing anchor or a field end.
// A result goes through the input register, then the result register.
// Throughput: one input byte per cycle while out_ready holds; an anchor
// match emits ANCHOR_LEN results, one per cycle while out_ready holds, and
// holds off the input meanwhile. The single output register sets this rate.
// cfg_we writes cfg_wdata into the capture length; write only while idle.
// Reset (rst_n low at a clock edge) empties both registers, restores the
// capture length to 800 and returns to marker search.
// A stalled receiver holds the result register, which backs up the input
// register and then drops in_ready; no transaction is lost.
`default_nettype none
`include "base64_field_anchor_extractor_macros.svh"

module base64_field_anchor_extractor #(
  parameter int unsigned MARKER_LEN  = bfae_pkg::MARKER_LEN_DEF,
  parameter int unsigned ANCHOR_LEN  = bfae_pkg::ANCHOR_LEN_DEF,
  parameter int unsigned CAPTURE_MAX = bfae_pkg::CAPTURE_MAX_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire bfae_pkg::in_item_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output bfae_pkg::out_item_t               out_data,
  input  wire logic                         cfg_we,
  input  wire logic [bfae_pkg::CFG_W-1:0]   cfg_wdata
);

  import bfae_pkg::*;

  localparam int unsigned LIM_W = $clog2(CAPTURE_MAX + 1);
  localparam int unsigned CMP_W = (LIM_W > CFG_W) ? LIM_W : CFG_W;

  typedef enum logic [1:0] {
    PH_MARKER,
    PH_ANCHOR,
    PH_CAPTURE,
    PH_DONE
  } phase_t;

  // Registers.
  logic                     s1_valid_r;
  in_item_t                 s1_data_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;
  logic [CFG_W-1:0]         cap_len_r;
  phase_t                   phase_r,    phase_nxt;
  logic [MPOS_W-1:0]        mpos_r,     mpos_nxt;
  logic [APOS_W-1:0]        apos_r,     apos_nxt;
  logic [ACC_W-1:0]         acc_r,      acc_nxt;
  logic signed [3:0]        pend_r,     pend_nxt;
  logic [CNT_W-1:0]         cnt_r,      cnt_nxt;
  logic [APOS_W-1:0]        burst_rem_r;
  logic [APOS_W-1:0]        burst_idx_r;
  logic                     burst_end_r;

  // Combinational work signals.
  logic                     out_fire;
  logic                     out_can_load;
  logic                     s1_adv;
  logic                     res_load;
  out_item_t                res;
  logic                     burst_start;
  logic                     burst_ends;
  phase_t                   ph_c;
  logic [MPOS_W-1:0]        mpos_c;
  logic [APOS_W-1:0]        apos_c;
  logic [ACC_W-1:0]         acc_c;
  logic signed [3:0]        pend_c;
  logic [CNT_W-1:0]         cnt_c;
  logic [BYTE_W-1:0]        ch;
  logic [6:0]               six;
  logic                     is_quote;
  logic [ACC_W-1:0]         acc_new;
  logic signed [3:0]        pend_new;
  logic                     byte_ok;
  logic [BYTE_W-1:0]        dec_byte;
  logic [MPOS_W:0]          mp1;
  logic [APOS_W:0]          ap1;
  logic [CMP_W-1:0]         limit;
  logic                     cap_full;

  // Handshake: the result register takes a new result when empty or draining
  // its final beat.
  assign out_fire     = out_valid_r && out_ready;
  assign out_can_load = !out_valid_r || (out_ready && (burst_rem_r == '0));
  assign s1_adv       = s1_valid_r && out_can_load;
  assign in_ready     = !s1_valid_r || out_can_load;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  // Effective capture limit.
  always_comb begin
    if (CMP_W'(cap_len_r) < CMP_W'(CAPTURE_MAX)) begin
      limit = CMP_W'(cap_len_r);
    end else begin
      limit = CMP_W'(CAPTURE_MAX);
    end
  end

  // Matching state as seen by the staged byte, after an optional restart.
  always_comb begin
    if (s1_data_r.start_req) begin
      ph_c   = PH_MARKER;
      mpos_c = '0;
      apos_c = '0;
      acc_c  = '0;
      pend_c = -4'sd8;
      cnt_c  = '0;
    end else begin
      ph_c   = phase_r;
      mpos_c = mpos_r;
      apos_c = apos_r;
      acc_c  = acc_r;
      pend_c = pend_r;
      cnt_c  = cnt_r;
    end
  end

  // Base64 decode of the staged byte.
  assign ch       = s1_data_r.in_byte;
  assign six      = sextet_of(ch);
  assign is_quote = (ch == "\"");
  assign acc_new  = {acc_c[ACC_W-7:0], six[5:0]};
  assign pend_new = pend_c + 4'sd6;
  assign byte_ok  = six[6] && (pend_new >= 4'sd0);
  assign dec_byte = BYTE_W'(acc_new >> pend_new[2:0]);

  // Pattern match steps with the simple fallback rule.
  always_comb begin
    if (ch == key_byte(mpos_c)) begin
      mp1 = {1'b0, mpos_c} + 1'b1;
    end else begin
      mp1 = (ch == key_byte('0)) ? (MPOS_W+1)'(1) : '0;
    end
    if (dec_byte == tag_byte(apos_c)) begin
      ap1 = {1'b0, apos_c} + 1'b1;
    end else begin
      ap1 = (dec_byte == tag_byte('0)) ? (APOS_W+1)'(1) : '0;
    end
  end

  assign burst_ends = (limit <= CMP_W'(ANCHOR_LEN));
  assign cap_full   = ((CMP_W+1)'(cnt_c) + 1'b1) >= {1'b0, limit};

  // Next matching state and the result of the staged transaction.
  always_comb begin
    phase_nxt   = ph_c;
    mpos_nxt    = mpos_c;
    apos_nxt    = apos_c;
    acc_nxt     = acc_c;
    pend_nxt    = pend_c;
    cnt_nxt     = cnt_c;
    res_load    = 1'b0;
    res         = '0;
    burst_start = 1'b0;
    if (s1_data_r.stream_end) begin
      case (ph_c)
        PH_MARKER: begin
          res_load   = 1'b1;
          res.status = ST_NO_FIELD;
          res.last   = 1'b1;
        end
        PH_ANCHOR: begin
          res_load   = 1'b1;
          res.status = ST_NO_ANCHOR;
          res.last   = 1'b1;
        end
        PH_CAPTURE: begin
          res_load   = 1'b1;
          res.status = ST_FIELD_END;
          res.last   = 1'b1;
        end
        default: begin
        end
      endcase
      phase_nxt = PH_DONE;
    end else begin
      case (ph_c)
        PH_MARKER: begin
          if (mp1 >= (MPOS_W+1)'(MARKER_LEN)) begin
            mpos_nxt  = '0;
            phase_nxt = PH_ANCHOR;
          end else begin
            mpos_nxt = mp1[MPOS_W-1:0];
          end
        end
        PH_ANCHOR, PH_CAPTURE: begin
          if (is_quote) begin
            res_load   = 1'b1;
            res.status = (ph_c == PH_ANCHOR) ? ST_NO_ANCHOR : ST_FIELD_END;
            res.last   = 1'b1;
            phase_nxt  = PH_DONE;
          end else if (six[6]) begin
            acc_nxt  = acc_new;
            pend_nxt = byte_ok ? (pend_new - 4'sd8) : pend_new;
            if (byte_ok && (ph_c == PH_ANCHOR)) begin
              apos_nxt = ap1[APOS_W-1:0];
              if (ap1 >= (APOS_W+1)'(ANCHOR_LEN)) begin
                // Anchor found: the first anchor byte goes out now, the rest
                // follow as a burst from the result register.
                res_load     = 1'b1;
                res.out_byte = tag_byte('0);
                res.status   = ST_DATA;
                res.last     = burst_ends && (ANCHOR_LEN == 1);
                burst_start  = 1'b1;
                cnt_nxt      = CNT_W'(ANCHOR_LEN);
                phase_nxt    = burst_ends ? PH_DONE : PH_CAPTURE;
              end
            end else if (byte_ok) begin
              cnt_nxt      = cnt_c + 1'b1;
              res_load     = 1'b1;
              res.out_byte = dec_byte;
              res.status   = ST_DATA;
              res.last     = cap_full;
              if (cap_full) begin
                phase_nxt = PH_DONE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State, staging register and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cap_len_r   <= CAP_LEN_RST;
      phase_r     <= PH_MARKER;
      mpos_r      <= '0;
      apos_r      <= '0;
      acc_r       <= '0;
      pend_r      <= -4'sd8;
      cnt_r       <= '0;
      burst_rem_r <= '0;
      burst_idx_r <= '0;
      burst_end_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_len_r <= cfg_wdata;
      end
      // Input staging register.
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
        s1_data_r  <= in_data;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      // Matching state advances with each staged transaction.
      if (s1_adv) begin
        phase_r <= phase_nxt;
        mpos_r  <= mpos_nxt;
        apos_r  <= apos_nxt;
        acc_r   <= acc_nxt;
        pend_r  <= pend_nxt;
        cnt_r   <= cnt_nxt;
      end
      // Result register and anchor burst.
      if (s1_adv && res_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
        if (burst_start) begin
          burst_rem_r <= APOS_W'(ANCHOR_LEN - 1);
          burst_idx_r <= APOS_W'(1);
          burst_end_r <= burst_ends;
        end
      end else if (out_fire) begin
        if (burst_rem_r != '0) begin
          out_data_r.out_byte <= tag_byte(burst_idx_r);
          out_data_r.status   <= ST_DATA;
          out_data_r.last     <= burst_end_r && (burst_rem_r == APOS_W'(1));
          burst_rem_r         <= burst_rem_r - 1'b1;
          burst_idx_r         <= burst_idx_r + 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  // A pending anchor burst always has a result on show.
  `BFAE_ASSERT_IMP(a_burst_shown, clk, rst_n, burst_rem_r != '0, out_valid_r)
  // No staged transaction advances while the burst is still going out.
  `BFAE_ASSERT_IMP(a_burst_blocks, clk, rst_n, burst_rem_r != '0, !s1_adv)
  // A staged transaction that cannot advance stays staged.
  `BFAE_ASSERT_NXT(a_stage_kept, clk, rst_n, s1_valid_r && !s1_adv, s1_valid_r)
  // Burst beats are data bytes.
  `BFAE_ASSERT_IMP(a_burst_data, clk, rst_n, out_valid_r && (burst_rem_r != '0),
                   out_data_r.status == ST_DATA)

endmodule

`default_nettype wire
